FILE: hw/rtl/led_strip_pattern_generator_defines.svh
// Assertion macros shared by the LED strip pattern generator RTL
`ifndef LED_STRIP_PATTERN_GENERATOR_DEFINES_SVH
`define LED_STRIP_PATTERN_GENERATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define LSPG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lspg assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define LSPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lspg assertion failed");

`endif

FILE: hw/rtl/lspg_pkg.sv
// Package: constants, types and color wheel of the LED strip pattern generator
package lspg_pkg;

  localparam int PIXEL_COUNT = 24;
  localparam int PIX_W = $clog2(PIXEL_COUNT);
  localparam int COLOR_W = 24;
  localparam int PNUM_W = 5;

  localparam logic [COLOR_W-1:0] WHITE_COLOR = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] BLACK_COLOR = 24'h000000;
  localparam logic [COLOR_W-1:0] BASE_COLOR_RESET = 24'hFF00FF;

  typedef enum logic [2:0] {
    MODE_ON            = 3'd0,
    MODE_DARK          = 3'd1,
    MODE_WHEEL         = 3'd2,
    MODE_STROBE        = 3'd3,
    MODE_CHASE         = 3'd4,
    MODE_CHASE_RAINBOW = 3'd5
  } mode_t;

  localparam logic [1:0] CFG_EFFECT_MODE = 2'd0;
  localparam logic [1:0] CFG_BASE_COLOR  = 2'd1;

  localparam logic [1:0] PHASE_LAST = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [1:0]       mod3;
    logic             last;
    logic [7:0]       hue;
    logic [1:0]       phase;
    logic             strobe;
  } pix_ctx_t;

  function automatic logic [COLOR_W-1:0] wheel_color(input logic [7:0] pos);
    logic [7:0] w;
    logic [7:0] ws;
    logic [9:0] w3;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [COLOR_W-1:0] c;
    w = 8'd255 - pos;
    if (w < 8'd85) begin
      ws = w;
    end else if (w < 8'd170) begin
      ws = w - 8'd85;
    end else begin
      ws = w - 8'd170;
    end
    w3 = 10'(ws) * 10'd3;
    lo = w3[7:0];
    hi = 8'd255 - lo;
    if (w < 8'd85) begin
      c = {hi, 8'd0, lo};
    end else if (w < 8'd170) begin
      c = {8'd0, lo, hi};
    end else begin
      c = {lo, hi, 8'd0};
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/lspg_frame_seq.sv
// Frame sequencer: takes tick items, steps through the pixels, holds effect state
`include "led_strip_pattern_generator_defines.svh"

module lspg_frame_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               frame_tick,
  output logic               in_stall,
  input  logic               adv,
  input  lspg_pkg::mode_t    mode,
  output logic               pix_valid,
  output lspg_pkg::pix_ctx_t ctx
);

  logic                       busy;
  logic [lspg_pkg::PIX_W-1:0] cnt;
  logic [1:0]                 mod3;
  logic [7:0]                 hue;
  logic [1:0]                 phase;
  logic                       strobe;

  logic [7:0] hue_next;
  logic [1:0] phase_next;
  logic       strobe_next;
  logic [1:0] phase_eff;
  logic       is_last;
  logic       issue_last;
  logic       accept;
  logic       start;

  assign is_last    = cnt == lspg_pkg::PIX_W'(lspg_pkg::PIXEL_COUNT - 1);
  assign issue_last = busy && adv && is_last;
  assign in_stall   = busy && !issue_last;
  assign accept     = in_valid && !in_stall;
  assign start      = accept && frame_tick;
  assign phase_eff  = (phase > lspg_pkg::PHASE_LAST) ? lspg_pkg::PHASE_LAST : phase;

  always_comb begin
    hue_next    = hue;
    phase_next  = phase;
    strobe_next = strobe;
    case (mode)
      lspg_pkg::MODE_WHEEL: begin
        hue_next = hue + 8'd1;
      end
      lspg_pkg::MODE_STROBE: begin
        strobe_next = !strobe;
      end
      lspg_pkg::MODE_CHASE: begin
        phase_next = (phase_eff == lspg_pkg::PHASE_LAST) ? 2'd0 : phase_eff + 2'd1;
      end
      lspg_pkg::MODE_CHASE_RAINBOW: begin
        if (phase_eff == lspg_pkg::PHASE_LAST) begin
          hue_next = hue + 8'd1;
        end
        phase_next = (phase_eff == lspg_pkg::PHASE_LAST) ? 2'd0 : phase_eff + 2'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      cnt    <= '0;
      mod3   <= 2'd0;
      hue    <= 8'd0;
      phase  <= 2'd0;
      strobe <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        mod3 <= 2'd0;
      end else if (busy && adv) begin
        if (is_last) begin
          busy <= 1'b0;
        end else begin
          cnt  <= cnt + 1'b1;
          mod3 <= (mod3 == 2'd2) ? 2'd0 : mod3 + 2'd1;
        end
      end
      if (issue_last) begin
        hue    <= hue_next;
        phase  <= phase_next;
        strobe <= strobe_next;
      end
    end
  end

  assign pix_valid  = busy;
  assign ctx.pix    = cnt;
  assign ctx.mod3   = mod3;
  assign ctx.last   = is_last;
  assign ctx.hue    = hue;
  assign ctx.phase  = phase_eff;
  assign ctx.strobe = strobe;

  `LSPG_ASSERT_NOW(a_phase_range, 1'b1, phase != 2'd3)
  `LSPG_ASSERT_NOW(a_mod3_start, busy && cnt == '0, mod3 == 2'd0)
  `LSPG_ASSERT_NEXT(a_frame_ends, issue_last && !(in_valid && frame_tick), !busy)

endmodule

FILE: hw/rtl/lspg_pixel_color.sv
// Pixel color logic: effect mode and frame state to the color of one pixel
module lspg_pixel_color (
  input  lspg_pkg::mode_t             mode,
  input  logic [lspg_pkg::COLOR_W-1:0] base_color,
  input  lspg_pkg::pix_ctx_t          ctx,
  output logic [lspg_pkg::COLOR_W-1:0] color
);

  logic       lit;
  logic [9:0] rb_sum;
  logic [9:0] cr_sum;
  logic [9:0] cr_mod;

  assign lit    = ctx.mod3 == ctx.phase;
  assign rb_sum = 10'(ctx.pix) + 10'(ctx.hue);
  assign cr_sum = 10'(ctx.pix) - 10'(ctx.phase) + 10'(ctx.hue);
  assign cr_mod = (cr_sum >= 10'd255) ? cr_sum - 10'd255 : cr_sum;

  always_comb begin
    case (mode)
      lspg_pkg::MODE_ON: begin
        color = base_color;
      end
      lspg_pkg::MODE_WHEEL: begin
        color = lspg_pkg::wheel_color(rb_sum[7:0]);
      end
      lspg_pkg::MODE_STROBE: begin
        color = ctx.strobe ? lspg_pkg::WHITE_COLOR : lspg_pkg::BLACK_COLOR;
      end
      lspg_pkg::MODE_CHASE: begin
        color = lit ? base_color : lspg_pkg::BLACK_COLOR;
      end
      lspg_pkg::MODE_CHASE_RAINBOW: begin
        color = lit ? lspg_pkg::wheel_color(cr_mod[7:0]) : lspg_pkg::BLACK_COLOR;
      end
      default: begin
        color = lspg_pkg::BLACK_COLOR;
      end
    endcase
  end

endmodule

FILE: hw/rtl/led_strip_pattern_generator.sv
// Top level of the LED strip pattern generator
// Usage:
// - Input channel (in_valid, in_stall, frame_tick): one item per frame request.
//   frame_tick = 1 starts a frame of PIXEL_COUNT pixel items; 0 is taken and dropped.
// - Output channel (out_valid, out_stall, pixel_number, pixel_color, last_pixel):
//   one item per pixel in strip order, last_pixel high on the final one.
// - Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 effect mode,
//   index 1 base color; cfg_ready is always high; write only while idle.
// Timing:
// - First pixel item: the taken tick item sets the sequencer's busy flag, then the
//   first pixel is loaded into the output register and out_valid rises.
// - One pixel per cycle unless out_stall holds it: a frame is PIXEL_COUNT (24)
//   pixels, set by the pixel counter. The next tick item is taken in the cycle
//   the last pixel issues, so frames run back to back.
// - Effect state (hue, chase phase, strobe) advances when a frame's last pixel issues.
// Reset: rst clears state, mode to on, base color to magenta, no item in flight.
// Stall: out_stall holds the output register; the pixel counter waits and in_stall
// stays high until the frame can finish.
`include "led_strip_pattern_generator_defines.svh"

module led_strip_pattern_generator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          frame_tick,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lspg_pkg::PNUM_W-1:0]   pixel_number,
  output logic [lspg_pkg::COLOR_W-1:0]  pixel_color,
  output logic                          last_pixel,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [lspg_pkg::COLOR_W-1:0]  cfg_data
);

  lspg_pkg::mode_t              effect_mode;
  logic [lspg_pkg::COLOR_W-1:0] base_color;

  logic                         out_load;
  logic                         adv;
  logic                         pix_valid;
  lspg_pkg::pix_ctx_t           ctx;
  logic [lspg_pkg::COLOR_W-1:0] color;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode <= lspg_pkg::MODE_ON;
      base_color  <= lspg_pkg::BASE_COLOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lspg_pkg::CFG_EFFECT_MODE: begin
          effect_mode <= lspg_pkg::mode_t'(cfg_data[2:0]);
        end
        lspg_pkg::CFG_BASE_COLOR: begin
          base_color <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_load = !out_valid || !out_stall;
  assign adv      = pix_valid && out_load;

  lspg_frame_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .frame_tick (frame_tick),
    .in_stall   (in_stall),
    .adv        (adv),
    .mode       (effect_mode),
    .pix_valid  (pix_valid),
    .ctx        (ctx)
  );

  lspg_pixel_color u_color (
    .mode       (effect_mode),
    .base_color (base_color),
    .ctx        (ctx),
    .color      (color)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_number <= lspg_pkg::PNUM_W'(ctx.pix);
      pixel_color  <= color;
      last_pixel   <= ctx.last;
    end
  end

  `LSPG_ASSERT_NOW(a_last_number, out_valid && last_pixel,
    pixel_number == lspg_pkg::PNUM_W'(lspg_pkg::PIXEL_COUNT - 1))
  `LSPG_ASSERT_NEXT(a_cfg_mode, cfg_valid && cfg_index == lspg_pkg::CFG_EFFECT_MODE,
    effect_mode == $past(cfg_data[2:0]))
  `LSPG_ASSERT_NEXT(a_cfg_color, cfg_valid && cfg_index == lspg_pkg::CFG_BASE_COLOR,
    base_color == $past(cfg_data))

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the LED strip pattern generator: modes, state, stalls
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [lspg_pkg::PNUM_W-1:0]  idx;
    logic [lspg_pkg::COLOR_W-1:0] color;
    logic                         last;
  } pixel_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic                          frame_tick;
  logic                          out_valid;
  logic                          out_stall;
  logic [lspg_pkg::PNUM_W-1:0]   pixel_number;
  logic [lspg_pkg::COLOR_W-1:0]  pixel_color;
  logic                          last_pixel;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [1:0]                    cfg_index;
  logic [lspg_pkg::COLOR_W-1:0]  cfg_data;

  pixel_t                        pending_pixels[$];
  int                            mismatches;
  int                            quiet_cycles;
  int                            rx_hold;
  bit                            tx_idle;
  bit                            rx_idle;

  logic [2:0]                    cur_mode;
  logic [lspg_pkg::COLOR_W-1:0]  cur_base;
  logic [7:0]                    hue_ofs;
  logic [1:0]                    chase_ph;
  logic                          strobe_on;

  led_strip_pattern_generator dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .frame_tick   (frame_tick),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_number (pixel_number),
    .pixel_color  (pixel_color),
    .last_pixel   (last_pixel),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [lspg_pkg::COLOR_W-1:0] wheel_at(int pos);
    int w;
    w = 255 - (pos & 255);
    if (w < 85) begin
      return {8'(255 - 3 * w), 8'd0, 8'(3 * w)};
    end
    if (w < 170) begin
      w = w - 85;
      return {8'd0, 8'(3 * w), 8'(255 - 3 * w)};
    end
    w = w - 170;
    return {8'(3 * w), 8'(255 - 3 * w), 8'd0};
  endfunction

  function automatic void paint_frame(bit tick);
    int ph;
    pixel_t px;
    logic [lspg_pkg::COLOR_W-1:0] c;
    if (!tick) begin
      return;
    end
    ph = (chase_ph > 2'd2) ? 2 : int'(chase_ph);
    for (int p = 0; p < lspg_pkg::PIXEL_COUNT; p++) begin
      case (cur_mode)
        lspg_pkg::MODE_ON: c = cur_base;
        lspg_pkg::MODE_WHEEL: c = wheel_at((p + hue_ofs) & 255);
        lspg_pkg::MODE_STROBE: c = strobe_on ? lspg_pkg::WHITE_COLOR : lspg_pkg::BLACK_COLOR;
        lspg_pkg::MODE_CHASE: c = ((p % 3) == ph) ? cur_base : lspg_pkg::BLACK_COLOR;
        lspg_pkg::MODE_CHASE_RAINBOW: c = ((p % 3) == ph) ?
          wheel_at((p - ph + hue_ofs) % 255) : lspg_pkg::BLACK_COLOR;
        default: c = lspg_pkg::BLACK_COLOR;
      endcase
      px.idx = lspg_pkg::PNUM_W'(p);
      px.color = c;
      px.last = (p == lspg_pkg::PIXEL_COUNT - 1);
      pending_pixels.push_back(px);
    end
    case (cur_mode)
      lspg_pkg::MODE_WHEEL: hue_ofs = hue_ofs + 8'd1;
      lspg_pkg::MODE_STROBE: strobe_on = ~strobe_on;
      lspg_pkg::MODE_CHASE: chase_ph = (ph >= 2) ? 2'd0 : 2'(ph + 1);
      lspg_pkg::MODE_CHASE_RAINBOW: begin
        if (ph >= 2) begin
          hue_ofs = hue_ofs + 8'd1;
        end
        chase_ph = (ph >= 2) ? 2'd0 : 2'(ph + 1);
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(string what, logic [lspg_pkg::COLOR_W-1:0] expv,
                                        logic [lspg_pkg::COLOR_W-1:0] actv);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, expv, actv);
    end
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        note_mismatch("unexpected pixel item", '0, pixel_color);
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_number !== want.idx) note_mismatch("pixel_number", want.idx, pixel_number);
        if (pixel_color !== want.color) note_mismatch("pixel_color", want.color, pixel_color);
        if (last_pixel !== want.last) note_mismatch("last_pixel", want.last, last_pixel);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int waits;
    out_stall <= 1'b0;
    @(negedge clk);
    forever begin
      waits = rx_hold + (rx_idle ? $urandom_range(0, 19) : 0);
      rx_hold = 0;
      if (waits > 0) begin
        out_stall <= 1'b1;
        repeat (waits) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_request(bit tick);
    int gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      frame_tick <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    frame_tick <= tick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    paint_frame(tick);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [lspg_pkg::COLOR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (index == lspg_pkg::CFG_EFFECT_MODE) begin
      cur_mode = data[2:0];
    end else if (index == lspg_pkg::CFG_BASE_COLOR) begin
      cur_base = data;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_mode(logic [2:0] mode);
    write_reg(lspg_pkg::CFG_EFFECT_MODE, {21'($urandom), mode});
  endtask

  task automatic test_reset_defaults();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    settle();
  endtask

  task automatic test_each_mode();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    write_reg(lspg_pkg::CFG_BASE_COLOR, 24'h000000);
    send_request(1'b1);
    settle();
    write_reg(lspg_pkg::CFG_BASE_COLOR, 24'hFFFFFF);
    write_reg(CFG_SPARE, 24'($urandom));
    send_request(1'b1);
    settle();
    set_mode(lspg_pkg::MODE_DARK);
    send_request(1'b1);
    settle();
    set_mode(lspg_pkg::MODE_WHEEL);
    repeat (2) send_request(1'b1);
    settle();
    set_mode(lspg_pkg::MODE_STROBE);
    repeat (3) send_request(1'b1);
    settle();
    write_reg(lspg_pkg::CFG_BASE_COLOR, 24'h123456);
    set_mode(lspg_pkg::MODE_CHASE);
    repeat (4) send_request(1'b1);
    settle();
    set_mode(lspg_pkg::MODE_CHASE_RAINBOW);
    repeat (4) send_request(1'b1);
    send_request(1'b0);
    settle();
    set_mode(MODE_SPARE_6);
    send_request(1'b1);
    settle();
    set_mode(MODE_SPARE_7);
    send_request(1'b1);
    settle();
    set_mode(lspg_pkg::MODE_WHEEL);
    send_request(1'b1);
    settle();
  endtask

  task automatic test_output_backpressure();
    set_mode(lspg_pkg::MODE_CHASE_RAINBOW);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 300;
    repeat (6) send_request(1'b1);
    settle();
  endtask

  task automatic test_random_frames();
    int ticks;
    bit tick;
    logic [lspg_pkg::COLOR_W-1:0] color;
    repeat (6) begin
      case ($urandom_range(0, 3))
        0: color = 24'h000000;
        1: color = 24'hFFFFFF;
        default: color = 24'($urandom);
      endcase
      write_reg(lspg_pkg::CFG_BASE_COLOR, color);
      set_mode(3'($urandom_range(0, 7)));
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      ticks = 0;
      while (ticks < 12) begin
        tick = ($urandom_range(0, 6) != 0);
        send_request(tick);
        if (tick) ticks++;
      end
      settle();
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    frame_tick <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= lspg_pkg::CFG_EFFECT_MODE;
    cfg_data <= '0;
    rx_hold = 0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    cur_mode = lspg_pkg::MODE_ON;
    cur_base = lspg_pkg::BASE_COLOR_RESET;
    hue_ofs = 8'd0;
    chase_ph = 2'd0;
    strobe_on = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);
    test_reset_defaults();
    test_each_mode();
    test_output_backpressure();
    test_random_frames();
    settle();
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
